>>> hw/rtl/mbtr_pkg.sv
// ----------------------------------------------------------------------------
// mbtr_pkg
// Types and constants shared by the Modbus TCP read transaction engine.
// ----------------------------------------------------------------------------
package mbtr_pkg;

  // Largest register count that one read may ask for
  localparam int unsigned MaxRegisters = 125;

  // Fixed MBAP length field of the request (unit + function + 4 bytes)
  localparam logic [7:0] MbapReqLength = 8'd6;

  // Bounds on the MBAP length field that a response may announce
  localparam logic [15:0] MaxHeaderLength = 16'd254;
  localparam logic [15:0] MinHeaderLength = 16'd2;

  // Exception flag in the response function byte
  localparam int unsigned FuncExcBit = 7;

  // Result kinds
  localparam logic [1:0] KindReqByte = 2'd0;
  localparam logic [1:0] KindRegWord = 2'd1;
  localparam logic [1:0] KindStatus  = 2'd2;

  // Completion status codes
  localparam logic [2:0] StOk          = 3'd0;
  localparam logic [2:0] StBadQuantity = 3'd1;
  localparam logic [2:0] StBadLength   = 3'd2;
  localparam logic [2:0] StPduTooLarge = 3'd3;
  localparam logic [2:0] StException   = 3'd4;
  localparam logic [2:0] StCountMism   = 3'd5;
  localparam logic [2:0] StShortPdu    = 3'd6;

  // Warning flag bit positions
  localparam int unsigned WarnTid   = 0;
  localparam int unsigned WarnProto = 1;
  localparam int unsigned WarnUnit  = 2;

  // Input item as seen on the push side
  typedef struct packed {
    logic        req_type;
    logic [7:0]  unit_id;
    logic [7:0]  func_code;
    logic [15:0] reg_addr;
    logic [15:0] quantity;
    logic [7:0]  rx_byte;
  } in_item_t;

  // Result item as seen on the pop side
  typedef struct packed {
    logic [1:0]  out_kind;
    logic [15:0] out_data;
    logic [6:0]  reg_index;
    logic [2:0]  status;
    logic [7:0]  exception_code;
    logic [2:0]  warn_flags;
    logic        last;
  } out_item_t;

  // Command classes decided by the front end
  typedef enum logic [1:0] {
    CMD_START_OK  = 2'd0,
    CMD_START_BAD = 2'd1,
    CMD_RX_BYTE   = 2'd2
  } cmd_kind_e;

  // Classified command between front and back end
  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  unit_id;
    logic [7:0]  func_code;
    logic [15:0] reg_addr;
    logic [6:0]  quantity;
    logic [7:0]  rx_byte;
  } cmd_t;

endpackage

>>> hw/rtl/mbtr_fifo.sv
// ----------------------------------------------------------------------------
// mbtr_fifo
// Small register FIFO with full/empty flags; push and pop in the same cycle.
// ----------------------------------------------------------------------------
module mbtr_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [Width-1:0] data_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> hw/rtl/mbtr_front.sv
// ----------------------------------------------------------------------------
// mbtr_front
// Takes input items, checks the start quantity and queues classified commands.
// ----------------------------------------------------------------------------
module mbtr_front import mbtr_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  in_item_t item_i,
  output logic     full_o,
  input  logic     cmd_pop_i,
  output logic     cmd_valid_o,
  output cmd_t     cmd_o
);

  cmd_t cmd_in;
  logic cmd_empty;
  logic qty_bad;

  // Quantity range check for start items
  assign qty_bad = (item_i.quantity == '0) || (item_i.quantity > 16'(MaxRegisters));

  always_comb begin
    cmd_in.unit_id   = item_i.unit_id;
    cmd_in.func_code = item_i.func_code;
    cmd_in.reg_addr  = item_i.reg_addr;
    cmd_in.quantity  = item_i.quantity[6:0];
    cmd_in.rx_byte   = item_i.rx_byte;
    if (item_i.req_type) begin
      cmd_in.kind = CMD_RX_BYTE;
    end else if (qty_bad) begin
      cmd_in.kind = CMD_START_BAD;
    end else begin
      cmd_in.kind = CMD_START_OK;
    end
  end

  // Command queue towards the back end
  mbtr_fifo #(
    .Width ($bits(cmd_t)),
    .Depth (Depth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (cmd_in),
    .full_o  (full_o),
    .pop_i   (cmd_pop_i),
    .empty_o (cmd_empty),
    .data_o  (cmd_o)
  );

  assign cmd_valid_o = !cmd_empty;

endmodule

>>> hw/rtl/mbtr_back.sv
// ----------------------------------------------------------------------------
// mbtr_back
// Transaction engine: sends request bytes, parses the response byte stream
// and produces register words and the completion status.
// ----------------------------------------------------------------------------
module mbtr_back import mbtr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  input  cmd_t      cmd_i,
  output logic      cmd_pop_o,
  input  logic      res_ready_i,
  output logic      res_valid_o,
  output out_item_t res_o
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_HEADER = 5'b00010,
    ST_PDU    = 5'b00100,
    ST_SEND   = 5'b01000,
    ST_FINISH = 5'b10000
  } state_e;

  state_e      state_q, state_d;
  logic [15:0] txn_cnt_q, txn_cnt_d;
  logic [15:0] sent_tid_q, sent_tid_d;
  logic [7:0]  exp_unit_q, exp_unit_d;
  logic [7:0]  exp_func_q, exp_func_d;
  logic [6:0]  exp_qty_q, exp_qty_d;
  logic [15:0] addr_q, addr_d;
  logic [7:0]  pos_q, pos_d;
  logic [15:0] hdr_len_q, hdr_len_d;
  logic [7:0]  held_q, held_d;
  logic [6:0]  word_idx_q, word_idx_d;
  logic [2:0]  warn_q, warn_d;
  logic [2:0]  pend_st_q, pend_st_d;
  logic [7:0]  pend_exc_q, pend_exc_d;
  logic [3:0]  tx_cnt_q, tx_cnt_d;

  logic        can_take;
  logic [7:0]  b;
  logic [7:0]  tx_byte;
  logic [7:0]  plen;
  logic [7:0]  two_qty;
  logic [7:0]  need;
  logic [2:0]  st_n;
  logic [7:0]  exc_n;
  logic        word_hit;
  logic        pdu_done;

  function automatic out_item_t mk_status(logic [2:0] st, logic [7:0] exc, logic [2:0] warn);
    out_item_t r;
    r                = '0;
    r.out_kind       = KindStatus;
    r.status         = st;
    r.exception_code = exc;
    r.warn_flags     = warn;
    r.last           = 1'b1;
    return r;
  endfunction

  function automatic out_item_t mk_byte(logic [7:0] d, logic lst);
    out_item_t r;
    r          = '0;
    r.out_kind = KindReqByte;
    r.out_data = {8'h00, d};
    r.last     = lst;
    return r;
  endfunction

  assign b         = cmd_i.rx_byte;
  assign can_take  = (state_q == ST_IDLE) || (state_q == ST_HEADER) || (state_q == ST_PDU);
  assign cmd_pop_o = cmd_valid_i && res_ready_i && can_take;

  // Request byte selection during the send burst
  always_comb begin
    unique case (tx_cnt_q)
      4'd1:    tx_byte = sent_tid_q[7:0];
      4'd5:    tx_byte = MbapReqLength;
      4'd6:    tx_byte = exp_unit_q;
      4'd7:    tx_byte = exp_func_q;
      4'd8:    tx_byte = addr_q[15:8];
      4'd9:    tx_byte = addr_q[7:0];
      4'd11:   tx_byte = {1'b0, exp_qty_q};
      default: tx_byte = 8'h00;
    endcase
  end

  // PDU size arithmetic
  assign plen    = hdr_len_q[7:0] - 8'd1;
  assign two_qty = {exp_qty_q, 1'b0};
  assign need    = two_qty + 8'd2;

  // Main sequencing
  always_comb begin
    state_d    = state_q;
    txn_cnt_d  = txn_cnt_q;
    sent_tid_d = sent_tid_q;
    exp_unit_d = exp_unit_q;
    exp_func_d = exp_func_q;
    exp_qty_d  = exp_qty_q;
    addr_d     = addr_q;
    pos_d      = pos_q;
    hdr_len_d  = hdr_len_q;
    held_d     = held_q;
    word_idx_d = word_idx_q;
    warn_d     = warn_q;
    pend_st_d  = pend_st_q;
    pend_exc_d = pend_exc_q;
    tx_cnt_d   = tx_cnt_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    st_n        = pend_st_q;
    exc_n       = pend_exc_q;
    word_hit    = 1'b0;
    pdu_done    = ({1'b0, pos_q} + 9'd1) >= {1'b0, plen};

    unique case (state_q)
      ST_SEND: begin
        if (res_ready_i) begin
          res_valid_o = 1'b1;
          res_o       = mk_byte(tx_byte, tx_cnt_q == 4'd11);
          if (tx_cnt_q == 4'd11) begin
            state_d = ST_HEADER;
          end else begin
            tx_cnt_d = tx_cnt_q + 4'd1;
          end
        end
      end
      ST_FINISH: begin
        if (res_ready_i) begin
          res_valid_o = 1'b1;
          res_o = mk_status(pend_st_q, (pend_st_q == StException) ? pend_exc_q : 8'h00,
                            warn_q);
          state_d = ST_IDLE;
        end
      end
      ST_IDLE, ST_HEADER, ST_PDU: begin
        if (cmd_pop_o) begin
          unique case (cmd_i.kind)
            CMD_START_BAD: begin
              warn_d      = '0;
              res_valid_o = 1'b1;
              res_o       = mk_status(StBadQuantity, 8'h00, 3'b000);
              state_d     = ST_IDLE;
            end
            CMD_START_OK: begin
              // First byte goes out at once, the rest in the send burst
              warn_d      = '0;
              res_valid_o = 1'b1;
              res_o       = mk_byte(txn_cnt_q[15:8], 1'b0);
              sent_tid_d  = txn_cnt_q;
              txn_cnt_d   = (txn_cnt_q == 16'hFFFF) ? 16'd1 : txn_cnt_q + 16'd1;
              exp_unit_d  = cmd_i.unit_id;
              exp_func_d  = cmd_i.func_code;
              exp_qty_d   = cmd_i.quantity;
              addr_d      = cmd_i.reg_addr;
              pos_d       = '0;
              hdr_len_d   = '0;
              held_d      = '0;
              word_idx_d  = '0;
              pend_st_d   = StOk;
              pend_exc_d  = '0;
              tx_cnt_d    = 4'd1;
              state_d     = ST_SEND;
            end
            CMD_RX_BYTE: begin
              if (state_q == ST_HEADER) begin
                // MBAP header checks
                if (pos_q == 8'd1 && {held_q, b} != sent_tid_q) begin
                  warn_d[WarnTid] = 1'b1;
                end
                if ((pos_q == 8'd2 || pos_q == 8'd3) && b != 8'h00) begin
                  warn_d[WarnProto] = 1'b1;
                end
                if (pos_q == 8'd5) begin
                  hdr_len_d = {held_q, b};
                end
                if (pos_q >= 8'd6) begin
                  if (b != exp_unit_q) begin
                    warn_d[WarnUnit] = 1'b1;
                  end
                  priority if (hdr_len_q < MinHeaderLength) begin
                    res_valid_o = 1'b1;
                    res_o       = mk_status(StBadLength, 8'h00, warn_d);
                    state_d     = ST_IDLE;
                  end else if (hdr_len_q > MaxHeaderLength) begin
                    res_valid_o = 1'b1;
                    res_o       = mk_status(StPduTooLarge, 8'h00, warn_d);
                    state_d     = ST_IDLE;
                  end else begin
                    state_d    = ST_PDU;
                    pos_d      = '0;
                    word_idx_d = '0;
                    pend_st_d  = StOk;
                    pend_exc_d = '0;
                    held_d     = b;
                  end
                end else begin
                  held_d = b;
                  pos_d  = pos_q + 8'd1;
                end
              end else if (state_q == ST_PDU) begin
                // PDU: function, byte count, then register data
                if (pos_q == 8'd0) begin
                  if (b[FuncExcBit] || b != exp_func_q) begin
                    st_n = StException;
                  end
                  if (plen < 8'd2) begin
                    st_n = StShortPdu;
                  end
                end else if (pos_q == 8'd1) begin
                  priority if (pend_st_q == StException) begin
                    exc_n = b;
                  end else if (b != two_qty) begin
                    st_n = StCountMism;
                  end else if (plen < need) begin
                    st_n = StShortPdu;
                  end
                end else if (pos_q[0] && pend_st_q == StOk && word_idx_q < exp_qty_q) begin
                  word_hit = 1'b1;
                end
                held_d     = b;
                pend_st_d  = st_n;
                pend_exc_d = exc_n;
                if (word_hit) begin
                  res_valid_o        = 1'b1;
                  res_o              = '0;
                  res_o.out_kind     = KindRegWord;
                  res_o.out_data     = {held_q, b};
                  res_o.reg_index    = word_idx_q;
                  word_idx_d         = word_idx_q + 7'd1;
                end
                if (pdu_done) begin
                  if (word_hit) begin
                    state_d = ST_FINISH;
                  end else begin
                    res_valid_o = 1'b1;
                    res_o = mk_status(st_n, (st_n == StException) ? exc_n : 8'h00, warn_q);
                    state_d = ST_IDLE;
                  end
                end else begin
                  pos_d = pos_q + 8'd1;
                end
              end
            end
            default: begin
              state_d = state_q;
            end
          endcase
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      txn_cnt_q  <= 16'd1;
      sent_tid_q <= '0;
      exp_unit_q <= '0;
      exp_func_q <= '0;
      exp_qty_q  <= '0;
      addr_q     <= '0;
      pos_q      <= '0;
      hdr_len_q  <= '0;
      held_q     <= '0;
      word_idx_q <= '0;
      warn_q     <= '0;
      pend_st_q  <= StOk;
      pend_exc_q <= '0;
      tx_cnt_q   <= '0;
    end else begin
      state_q    <= state_d;
      txn_cnt_q  <= txn_cnt_d;
      sent_tid_q <= sent_tid_d;
      exp_unit_q <= exp_unit_d;
      exp_func_q <= exp_func_d;
      exp_qty_q  <= exp_qty_d;
      addr_q     <= addr_d;
      pos_q      <= pos_d;
      hdr_len_q  <= hdr_len_d;
      held_q     <= held_d;
      word_idx_q <= word_idx_d;
      warn_q     <= warn_d;
      pend_st_q  <= pend_st_d;
      pend_exc_q <= pend_exc_d;
      tx_cnt_q   <= tx_cnt_d;
    end
  end

  // Checks
  a_txn_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    txn_cnt_q != 16'd0)
    else $error("transaction counter reached zero");

  a_send_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SEND |-> tx_cnt_q != 4'd0 && tx_cnt_q <= 4'd11)
    else $error("send counter out of range");

  a_last_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.out_kind == KindReqByte && res_o.last
      |-> state_q == ST_SEND && tx_cnt_q == 4'd11)
    else $error("last request byte out of place");

  a_finish_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FINISH |-> $past(state_q) == ST_PDU || $past(state_q) == ST_FINISH)
    else $error("finish entered from wrong state");

  a_word_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.out_kind == KindRegWord |-> res_o.reg_index < exp_qty_q)
    else $error("register word beyond requested quantity");

endmodule

>>> hw/rtl/modbus_tcp_read_transaction.sv
// ----------------------------------------------------------------------------
// modbus_tcp_read_transaction
// Modbus TCP client read engine: request builder and response parser.
//
//   channel  | handshake           | payload
//   ---------+---------------------+-------------------------
//   input    | push / full         | in_item_i  (in_item_t)
//   result   | pop / empty         | out_item_o (out_item_t)
//
// A response byte that closes the PDU on a register word gives two results:
// the word, then the status item. A valid start sends its 12 request bytes
// through the single result port, stalling while that port is full; a start
// with a bad quantity gives a single status item.
// Reset is asynchronous and needs no clearing pass; the id counter restarts
// at 1. The command queue (CmdDepth) and the result queue (OutDepth) let the
// input and result sides stall independently.
// ----------------------------------------------------------------------------
module modbus_tcp_read_transaction import mbtr_pkg::*; #(
  parameter int unsigned CmdDepth = 2,
  parameter int unsigned OutDepth = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  input  in_item_t  in_item_i,
  output logic      full,
  input  logic      pop,
  output logic      empty,
  output out_item_t out_item_o
);

  cmd_t      cmd;
  logic      cmd_valid;
  logic      cmd_pop;
  out_item_t res;
  logic      res_valid;
  logic      res_full;

  // Front end: classify and queue
  mbtr_front #(
    .Depth (CmdDepth)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .item_i      (in_item_i),
    .full_o      (full),
    .cmd_pop_i   (cmd_pop),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd)
  );

  // Back end: transaction engine
  mbtr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_ready_i (!res_full),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Result queue
  mbtr_fifo #(
    .Width ($bits(out_item_t)),
    .Depth (OutDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (out_item_o)
  );

endmodule

>>> test/tb_modbus_tcp_read_transaction.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_modbus_tcp_read_transaction
// Self-checking bench for the Modbus TCP read engine. Start items and
// response byte streams go in through the push side. An internal model of
// the request builder and response parser predicts every request byte,
// register word and status item. Each transfer on the pop side is checked
// against the oldest prediction. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_modbus_tcp_read_transaction;
  import mbtr_pkg::*;

  typedef enum logic [1:0] {
    PhIdle,
    PhHeader,
    PhPdu
  } phase_e;

  typedef logic [7:0] byte_q_t[$];

  // Engine model plus the queue of results still owed by the DUT
  class mbtr_scoreboard;
    phase_e      ph;
    logic [15:0] tid_ctr;
    logic [7:0]  exp_unit;
    logic [7:0]  exp_func;
    logic [6:0]  exp_qty;
    logic [7:0]  pos;
    logic [15:0] hdr_len;
    logic [7:0]  held;
    logic [6:0]  word_idx;
    logic [2:0]  warn;
    logic [2:0]  pend_st;
    logic [7:0]  pend_exc;
    out_item_t   due_items[$];
    int          errors;

    function new();
      ph       = PhIdle;
      tid_ctr  = 16'd1;
      exp_unit = '0;
      exp_func = '0;
      exp_qty  = '0;
      pos      = '0;
      hdr_len  = '0;
      held     = '0;
      word_idx = '0;
      warn     = '0;
      pend_st  = StOk;
      pend_exc = '0;
      errors   = 0;
    endfunction

    function void add_due(logic [1:0] kind, logic [15:0] data, logic [6:0] idx,
                          logic [2:0] st, logic [7:0] exc, logic [2:0] wf, logic lst);
      out_item_t o;
      o.out_kind       = kind;
      o.out_data       = data;
      o.reg_index      = idx;
      o.status         = st;
      o.exception_code = exc;
      o.warn_flags     = wf;
      o.last           = lst;
      due_items.push_back(o);
    endfunction

    // Status item ends the transaction
    function void close_txn(logic [2:0] st, logic [7:0] exc);
      add_due(KindStatus, 16'd0, 7'd0, st, exc, warn, 1'b1);
      ph = PhIdle;
    endfunction

    // Called once per accepted input transfer
    function void note_accepted(in_item_t it);
      logic [7:0]  req_bytes [12];
      logic [7:0]  b;
      logic [15:0] sent_id;
      int          plen;
      int          need;
      b = it.rx_byte;
      if (!it.req_type) begin
        // start: check quantity, then build the 12-byte request
        warn = '0;
        if (it.quantity == 16'd0 || it.quantity > MaxRegisters) begin
          close_txn(StBadQuantity, 8'd0);
          return;
        end
        req_bytes[0]  = tid_ctr[15:8];
        req_bytes[1]  = tid_ctr[7:0];
        req_bytes[2]  = 8'd0;
        req_bytes[3]  = 8'd0;
        req_bytes[4]  = 8'd0;
        req_bytes[5]  = MbapReqLength;
        req_bytes[6]  = it.unit_id;
        req_bytes[7]  = it.func_code;
        req_bytes[8]  = it.reg_addr[15:8];
        req_bytes[9]  = it.reg_addr[7:0];
        req_bytes[10] = it.quantity[15:8];
        req_bytes[11] = it.quantity[7:0];
        for (int i = 0; i < 12; i++) begin
          add_due(KindReqByte, {8'd0, req_bytes[i]}, 7'd0, StOk, 8'd0, 3'd0, i == 11);
        end
        tid_ctr = tid_ctr + 16'd1;
        if (tid_ctr == 16'd0) begin
          tid_ctr = 16'd1;
        end
        exp_unit = it.unit_id;
        exp_func = it.func_code;
        exp_qty  = it.quantity[6:0];
        pos      = '0;
        hdr_len  = '0;
        held     = '0;
        word_idx = '0;
        pend_st  = StOk;
        pend_exc = '0;
        ph       = PhHeader;
      end else if (ph == PhHeader) begin
        // MBAP header
        case (pos)
          8'd1: begin
            sent_id = (tid_ctr == 16'd1) ? 16'hFFFF : tid_ctr - 16'd1;
            if ({held, b} != sent_id) warn[WarnTid] = 1'b1;
          end
          8'd2, 8'd3: begin
            if (b != 8'd0) warn[WarnProto] = 1'b1;
          end
          8'd5: begin
            hdr_len = {held, b};
          end
          default: ;
        endcase
        if (pos >= 8'd6) begin
          if (b != exp_unit) warn[WarnUnit] = 1'b1;
          if (hdr_len < MinHeaderLength) begin
            close_txn(StBadLength, 8'd0);
          end else if (hdr_len > MaxHeaderLength) begin
            close_txn(StPduTooLarge, 8'd0);
          end else begin
            ph       = PhPdu;
            pos      = '0;
            word_idx = '0;
            pend_st  = StOk;
            pend_exc = '0;
            held     = b;
          end
          return;
        end
        held = b;
        pos  = pos + 8'd1;
      end else if (ph == PhPdu) begin
        // PDU: function, byte count, then register words
        plen = int'(hdr_len) - 1;
        need = 2 + 2 * int'(exp_qty);
        if (pos == 8'd0) begin
          if (b[FuncExcBit] || b != exp_func) pend_st = StException;
          if (plen < 2) pend_st = StShortPdu;
        end else if (pos == 8'd1) begin
          if (pend_st == StException) pend_exc = b;
          else if (int'(b) != 2 * int'(exp_qty)) pend_st = StCountMism;
          else if (plen < need) pend_st = StShortPdu;
        end else if (pos[0] && pend_st == StOk && word_idx < exp_qty) begin
          add_due(KindRegWord, {held, b}, word_idx, StOk, 8'd0, 3'd0, 1'b0);
          word_idx = word_idx + 7'd1;
        end
        held = b;
        if (int'(pos) + 1 >= plen) begin
          close_txn(pend_st, (pend_st == StException) ? pend_exc : 8'd0);
        end else begin
          pos = pos + 8'd1;
        end
      end
    endfunction

    // Called once per result transfer
    function void check_popped(out_item_t got);
      out_item_t want;
      bit        bad;
      if (due_items.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: unexpected result kind %0d data %h idx %0d st %0d exc %h warn %b last %b",
                   $realtime, got.out_kind, got.out_data, got.reg_index, got.status,
                   got.exception_code, got.warn_flags, got.last);
        end
        return;
      end
      want = due_items.pop_front();
      bad  = (got.out_kind !== want.out_kind) || (got.out_data !== want.out_data) ||
             (got.reg_index !== want.reg_index) || (got.status !== want.status) ||
             (got.exception_code !== want.exception_code) ||
             (got.warn_flags !== want.warn_flags) || (got.last !== want.last);
      if (bad) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: mismatch, expected kind %0d data %h idx %0d st %0d exc %h warn %b last %b",
                   $realtime, want.out_kind, want.out_data, want.reg_index, want.status,
                   want.exception_code, want.warn_flags, want.last);
          $display("%0t:           actual   kind %0d data %h idx %0d st %0d exc %h warn %b last %b",
                   $realtime, got.out_kind, got.out_data, got.reg_index, got.status,
                   got.exception_code, got.warn_flags, got.last);
        end
      end
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      push = 1'b0;
  in_item_t  in_item = '0;
  logic      full;
  logic      pop = 1'b0;
  logic      empty;
  out_item_t out_item;

  mbtr_scoreboard sb = new();
  bit             no_idle = 1'b0;
  int             item_count = 0;

  modbus_tcp_read_transaction i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .in_item_i  (in_item),
    .full       (full),
    .pop        (pop),
    .empty      (empty),
    .out_item_o (out_item)
  );

  always #4 clk_i = ~clk_i;

  // One input transfer, after a random gap
  task automatic send_item(input in_item_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push    <= 1'b1;
    in_item <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    // bytes that arrive while idle are dropped by the engine
    if (!it.req_type || sb.ph != PhIdle) item_count++;
    sb.note_accepted(it);
  endtask

  task automatic send_start(input logic [7:0] unit, input logic [7:0] func,
                            input logic [15:0] addr, input logic [15:0] qty);
    in_item_t it;
    it.req_type  = 1'b0;
    it.unit_id   = unit;
    it.func_code = func;
    it.reg_addr  = addr;
    it.quantity  = qty;
    it.rx_byte   = 8'($urandom);
    send_item(it);
  endtask

  // Unused start fields carry noise on byte transfers
  task automatic send_rx(input logic [7:0] b);
    in_item_t it;
    it.req_type  = 1'b1;
    it.unit_id   = 8'($urandom);
    it.func_code = 8'($urandom);
    it.reg_addr  = 16'($urandom);
    it.quantity  = 16'($urandom);
    it.rx_byte   = b;
    send_item(it);
  endtask

  task automatic send_bytes(input byte_q_t bytes);
    foreach (bytes[i]) send_rx(bytes[i]);
  endtask

  // Mostly small reads; now and then the largest, or a bad count
  task automatic send_rand_start(input bit valid);
    logic [15:0] q;
    logic [7:0]  f;
    int          r;
    r = $urandom_range(0, 99);
    if (valid) begin
      if (r < 80) q = 16'($urandom_range(1, 8));
      else if (r < 93) q = 16'($urandom_range(9, 124));
      else q = 16'(MaxRegisters);
    end else begin
      q = (r < 30) ? 16'd0 : 16'($urandom_range(126, 65535));
    end
    f = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(1, 4)) : 8'($urandom);
    send_start(8'($urandom), f, 16'($urandom), q);
  endtask

  // Response to the open request: mostly well formed, the rest broken
  task automatic send_response(input bit cut_short);
    byte_q_t     bytes;
    logic [15:0] tid;
    logic [15:0] len;
    logic [7:0]  unit;
    logic [7:0]  func;
    logic [7:0]  cnt;
    int          q;
    int          plen;
    int          r;
    int          n;
    q    = sb.exp_qty;
    tid  = (sb.tid_ctr == 16'd1) ? 16'hFFFF : sb.tid_ctr - 16'd1;
    unit = sb.exp_unit;
    func = sb.exp_func;
    cnt  = 8'(2 * q);
    plen = 2 + 2 * q;
    r    = $urandom_range(0, 99);
    if (r < 55) begin
      // good, sometimes with trailing bytes
      if ($urandom_range(0, 3) == 0) plen += $urandom_range(1, 4);
    end else if (r < 64) begin
      // exception reply
      func = ($urandom_range(0, 1) != 0) ? (func | 8'h80) : (func ^ 8'($urandom_range(1, 255)));
      cnt  = 8'($urandom);
      plen = $urandom_range(1, 4);
    end else if (r < 72) begin
      cnt = cnt ^ 8'($urandom_range(1, 255));
    end else if (r < 80) begin
      plen = $urandom_range(1, 1 + 2 * q);
    end
    if (plen > 253) plen = 253;
    len = 16'(plen + 1);
    if (r >= 80 && r < 88) len = 16'($urandom_range(0, 1));
    else if (r >= 88 && r < 95) len = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                                 : 16'($urandom_range(255, 65534));
    else if (r >= 95) len = 16'($urandom);
    // odd header fields that only raise warnings
    if ($urandom_range(0, 7) == 0) tid = tid ^ 16'($urandom_range(1, 65535));
    if ($urandom_range(0, 7) == 0) unit = unit ^ 8'($urandom_range(1, 255));
    bytes = {tid[15:8], tid[7:0], 8'd0, 8'd0, len[15:8], len[7:0], unit};
    if ($urandom_range(0, 7) == 0) bytes[2 + $urandom_range(0, 1)] = 8'($urandom_range(1, 255));
    if (len >= MinHeaderLength && len <= MaxHeaderLength) begin
      bytes.push_back(func);
      if (len > 16'd2) bytes.push_back(cnt);
      for (int i = 2; i < int'(len) - 1; i++) bytes.push_back(8'($urandom));
    end
    // abandoned mid-stream; the next start drops it
    if (cut_short) begin
      n = $urandom_range(1, bytes.size() - 1);
      while (bytes.size() > n) void'(bytes.pop_back());
    end
    send_bytes(bytes);
  endtask

  // Result side: random stalls, check each transfer
  initial begin
    int gap;
    wait (rst_ni);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
      sb.check_popped(out_item);
    end
  end

  // Stimulus
  initial begin
    byte_q_t dir_bytes;
    int      base;
    int      r;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // byte with no transaction open, then bad quantities at both ends
    send_rx(8'hFF);
    send_start(8'hFF, 8'hFF, 16'hFFFF, 16'd0);
    send_start(8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
    send_start(8'h00, 8'h03, 16'h0000, 16'd126);
    // largest read, abandoned by a new start
    send_start(8'h00, 8'h00, 16'h0000, 16'd125);
    send_start(8'hFF, 8'h03, 16'hFFFF, 16'd1);
    // clean one-word reply for id 2
    dir_bytes = {8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h05, 8'hFF, 8'h03, 8'h02, 8'hFF, 8'hFF};
    send_bytes(dir_bytes);
    // length of 1: bad length, with protocol and unit warnings
    send_start(8'h01, 8'h04, 16'h1234, 16'd2);
    dir_bytes = {8'h00, 8'h03, 8'hFF, 8'hFF, 8'h00, 8'h01, 8'h00};
    send_bytes(dir_bytes);

    // random transactions
    base = item_count;
    while (item_count < base + 430) begin
      no_idle = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 99);
      if (r < 8) begin
        repeat ($urandom_range(1, 3)) send_rx(8'($urandom));
      end else if (r < 20) begin
        send_rand_start(1'b0);
      end else begin
        send_rand_start(1'b1);
        send_response($urandom_range(0, 9) == 0);
      end
    end
    push    <= 1'b0;
    no_idle = 1'b0;

    // drain, then leave time for any stray result
    while (sb.due_items.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0 && sb.due_items.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #50000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
